>>> src/rstr_pkg.sv
// Shared types, constants and saturation helpers for the self-tuning regulator.
package rstr_pkg;

	localparam int REGRESSOR_COUNT      = 4;
	localparam int SIGNAL_FRAC_BITS_DEF = 16;
	localparam int COV_FRAC_BITS_DEF    = 32;
	localparam int LAMBDA_FRAC_BITS     = 16;

	localparam int SIG_W     = 32;
	localparam int EST_W     = 21;
	localparam int LAMBDA_W  = 17;
	localparam int LIMIT_W   = 31;
	localparam int ICOV_W    = 63;
	localparam int COV_W     = 64;
	localparam int CFG_W     = 63;
	localparam int CFG_IDX_W = 2;
	localparam int IN_W      = 6 * SIG_W;
	localparam int OUT_W     = 120;

	localparam logic [CFG_IDX_W-1:0] CFG_LAMBDA   = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_LIMIT    = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_INIT_COV = 2'd2;

	localparam logic [LAMBDA_W-1:0] LAMBDA_RST = 17'd65536;
	localparam logic [LIMIT_W-1:0]  LIMIT_RST  = 31'h7FFF_FFFF;

	localparam logic signed [63:0] S64_MAX = 64'sh7FFF_FFFF_FFFF_FFFF;
	localparam logic signed [63:0] S64_MIN = 64'sh8000_0000_0000_0000;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_FETCH,
		ST_MUL,
		ST_POST,
		ST_DIV,
		ST_DPOST,
		ST_OUT
	} state_t;

	typedef enum logic [2:0] {
		PH_TH,
		PH_PPHI,
		PH_WROW,
		PH_QUAD,
		PH_THU,
		PH_COV,
		PH_DRV
	} phase_t;

	function automatic logic signed [63:0] sat64(input logic signed [127:0] v);
		logic signed [63:0] r;
		if ((&v[127:63]) || !(|v[127:63])) r = v[63:0];
		else r = v[127] ? S64_MIN : S64_MAX;
		return r;
	endfunction

	function automatic logic signed [31:0] sat32(input logic signed [127:0] v);
		logic signed [31:0] r;
		if ((&v[127:31]) || !(|v[127:31])) r = v[31:0];
		else r = v[127] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
		return r;
	endfunction

	function automatic logic [63:0] mag64(input logic signed [63:0] v);
		logic [63:0] r;
		r = v[63] ? 64'(-v) : 64'(v);
		return r;
	endfunction

endpackage

>>> src/rls_self_tuning_regulator.sv
// Self-tuning regulator: RLS model estimate and one-step-ahead drive, shared mul/div unit.
//
// Input stream (s_*): one item per plant sample: setpoint, y(k), y(k-1), y(k-2),
// u(k-1), u(k-2), all Q16.16. Output stream (m_*): one item per input item with
// the clamped drive, the four updated model parameters and the zero-gain flag.
// Config port: cfg_we/cfg_index/cfg_data write lambda, drive limit and the
// initial covariance; a covariance write reloads the 4x4 covariance at once.
// Write it only while the block is idle.
//
// One item is worked through a sequencer driving a single 32x32 multiplier (64x64
// products in four passes) and a radix-2 divider. There are up to 37 quotients per
// item (4 parameter steps, 16+16 covariance steps, 1 drive, skipped when the gain
// is zero). s_tready is high only while idle, so one item is worked at a time.
// The result stays in the output register until m_tready takes it; the block
// accepts the next item the cycle after.
// Reset: parameters to 1.0, covariance to the diagonal default, registers to
// their defaults. The covariance sits in a 16-entry RAM with a valid bit per
// entry, so no clearing pass is needed.
module rls_self_tuning_regulator #(
	parameter int SIGNAL_FRAC_BITS = rstr_pkg::SIGNAL_FRAC_BITS_DEF,
	parameter int COV_FRAC_BITS    = rstr_pkg::COV_FRAC_BITS_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             s_tvalid,
	output logic                             s_tready,
	// setpoint, measured_now, output_prev1, output_prev2, drive_prev1, drive_prev2
	input  logic [rstr_pkg::IN_W-1:0]        s_tdata,
	output logic                             m_tvalid,
	input  logic                             m_tready,
	// drive, est_a1, est_a2, est_b0, est_b1, zero pad
	output logic [rstr_pkg::OUT_W-1:0]       m_tdata,
	// gain_zero
	output logic [0:0]                       m_tuser,
	input  logic                             cfg_we,
	input  logic [rstr_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [rstr_pkg::CFG_W-1:0]       cfg_data
);

	localparam int THETA_W   = SIGNAL_FRAC_BITS + 5;
	localparam int COV_DEPTH = rstr_pkg::REGRESSOR_COUNT * rstr_pkg::REGRESSOR_COUNT;
	localparam int COV_AW    = $clog2(COV_DEPTH);
	localparam int LAM_SHIFT = COV_FRAC_BITS - rstr_pkg::LAMBDA_FRAC_BITS;
	localparam logic [2:0] MUL_LAST = 3'd5;
	localparam logic [6:0] DIV_LAST = 7'(2 * rstr_pkg::COV_W - 1);
	localparam logic signed [THETA_W-1:0] THETA_ONE = THETA_W'(64'd1 << SIGNAL_FRAC_BITS);
	localparam logic signed [63:0] PMAX = 64'(64'd10 << SIGNAL_FRAC_BITS);
	localparam logic signed [63:0] DMAX = 64'sh1_0000_0000;
	localparam logic [rstr_pkg::ICOV_W-1:0] INIT_COV_RST =
		rstr_pkg::ICOV_W'(64'd1000000 << COV_FRAC_BITS);

	rstr_pkg::state_t state_q, state_d;
	rstr_pkg::phase_t phase_q;
	logic [3:0] idx_q;
	logic [2:0] mul_cnt_q;
	logic [6:0] div_cnt_q;
	logic       pass_q;

	logic [rstr_pkg::LAMBDA_W-1:0] lam_q;
	logic [rstr_pkg::LIMIT_W-1:0]  lim_q;
	logic [rstr_pkg::ICOV_W-1:0]   icov_q;
	logic [COV_DEPTH-1:0]          cov_vld_q;
	logic signed [THETA_W-1:0]     theta_q [4];

	logic signed [31:0] sp_q, y_q, y1_q, y2_q, u1_q, u2_q, err_q, drive_q;
	logic               flag_q;
	logic signed [63:0] pphi_q [4];
	logic signed [63:0] wrow_q [4];
	logic signed [63:0] d_q, cov_cur_q;
	logic signed [127:0] sum_q;

	logic [63:0]  ma_q, mb_q, pp_q;
	logic         mneg_q;
	logic [127:0] macc_q;

	logic [127:0] dn_q;
	logic [63:0]  dm_q, rem_q;
	logic         dneg_q;

	logic [1:0] i, j;
	logic       accept, adv, div_ld, cov_we, end_grp;
	logic [3:0] last_idx;
	logic signed [31:0] phi [4];
	logic [COV_AW-1:0] cov_addr;
	logic [63:0] ram_rdata;
	logic signed [63:0] cov_rd, op_a, op_b;
	logic [1:0] mk, ak;
	logic [31:0] a_part, b_part;
	logic [127:0] pp_sh;
	logic signed [127:0] prod, sum_nx, sum_sh, div_num;
	logic signed [63:0] div_den, q_res, quad_w, lam_term, d_w, g_w, g_sh, x_w, delta, t_w;
	logic signed [63:0] lim64;
	logic [rstr_pkg::LAMBDA_W-1:0] lam_eff;
	logic [64:0] rem_sh;
	logic        ge;
	logic [127:0] qv;
	logic signed [THETA_W-1:0] theta_new;
	logic signed [63:0] th64 [4];

	assign i = idx_q[3:2];
	assign j = idx_q[1:0];
	assign accept = s_tready && s_tvalid;

	// regressor
	always_comb begin
		phi[0] = rstr_pkg::sat32(-128'(y1_q));
		phi[1] = rstr_pkg::sat32(-128'(y2_q));
		phi[2] = u1_q;
		phi[3] = u2_q;
	end

	// entries never written since reload read as the diagonal default
	assign cov_addr = (phase_q == rstr_pkg::PH_WROW) ? {j, i} : {i, j};
	assign cov_rd = cov_vld_q[cov_addr] ? signed'(ram_rdata)
		: ((i == j) ? signed'({1'b0, icov_q}) : 64'sd0);

	always_comb begin
		op_a = '0;
		op_b = '0;
		case (phase_q)
			rstr_pkg::PH_TH: begin
				op_a = 64'(theta_q[j]);
				op_b = 64'(phi[j]);
			end
			rstr_pkg::PH_PPHI: begin
				op_a = cov_rd;
				op_b = 64'(phi[j]);
			end
			rstr_pkg::PH_WROW: begin
				op_a = 64'(phi[j]);
				op_b = cov_rd;
			end
			rstr_pkg::PH_QUAD: begin
				op_a = 64'(phi[j]);
				op_b = pphi_q[j];
			end
			rstr_pkg::PH_THU: begin
				op_a = pphi_q[j];
				op_b = 64'(err_q);
			end
			rstr_pkg::PH_COV: begin
				op_a = pphi_q[i];
				op_b = wrow_q[j];
			end
			rstr_pkg::PH_DRV: begin
				case (j)
					2'd0: begin
						op_a = 64'(theta_q[0]);
						op_b = 64'(y_q);
					end
					2'd1: begin
						op_a = 64'(theta_q[1]);
						op_b = 64'(y1_q);
					end
					default: begin
						op_a = 64'(theta_q[3]);
						op_b = 64'(u1_q);
					end
				endcase
			end
			default: ;
		endcase
	end

	// multiplier: four 32x32 partial products of the magnitudes
	always_comb begin
		mk = 2'(mul_cnt_q - 3'd1);
		ak = 2'(mul_cnt_q - 3'd2);
		a_part = mk[1] ? ma_q[63:32] : ma_q[31:0];
		b_part = mk[0] ? mb_q[63:32] : mb_q[31:0];
		case (ak)
			2'd0:    pp_sh = {64'd0, pp_q};
			2'd3:    pp_sh = {pp_q, 64'd0};
			default: pp_sh = {32'd0, pp_q, 32'd0};
		endcase
		prod = mneg_q ? -signed'(macc_q) : signed'(macc_q);
	end

	// divider step and saturated quotient
	always_comb begin
		rem_sh = {rem_q, dn_q[127]};
		ge = rem_sh >= {1'b0, dm_q};
		qv = dn_q;
		if ((|qv[127:64]) || (qv[63] && (|qv[62:0]))) begin
			q_res = dneg_q ? rstr_pkg::S64_MIN : rstr_pkg::S64_MAX;
		end else if (dneg_q) begin
			q_res = -signed'(qv[63:0]);
		end else if (qv[63]) begin
			q_res = rstr_pkg::S64_MAX;
		end else begin
			q_res = signed'(qv[63:0]);
		end
	end

	always_comb begin
		lam_eff  = (lam_q == '0) ? rstr_pkg::LAMBDA_W'(1) : lam_q;
		lam_term = signed'(64'(lam_eff) << LAM_SHIFT);
		lim64    = signed'(64'(lim_q));
		end_grp  = (phase_q == rstr_pkg::PH_DRV) ? (j == 2'd2) : (j == 2'd3);
		sum_nx   = sum_q + (((phase_q == rstr_pkg::PH_DRV) && (j == 2'd2)) ? -prod : prod);
		sum_sh   = sum_nx >>> SIGNAL_FRAC_BITS;
		quad_w   = rstr_pkg::sat64(sum_sh);
		d_w      = rstr_pkg::sat64(128'(lam_term) + 128'(quad_w));
		g_w      = 64'(128'(sp_q) + sum_sh);
		g_sh     = g_w <<< SIGNAL_FRAC_BITS;
		x_w      = rstr_pkg::sat64(128'(cov_cur_q) - 128'(q_res));
		delta    = q_res;
		if (delta > DMAX) delta = DMAX;
		if (delta < -DMAX) delta = -DMAX;
		t_w = 64'(theta_q[j]) + delta;
		if (t_w > PMAX) t_w = PMAX;
		if (t_w < -PMAX) t_w = -PMAX;
		theta_new = THETA_W'(t_w);
	end

	// quotient start: parameter and covariance steps, the lambda pass, the drive
	always_comb begin
		div_ld  = 1'b0;
		div_num = '0;
		div_den = '0;
		if (state_q == rstr_pkg::ST_POST) begin
			case (phase_q)
				rstr_pkg::PH_THU, rstr_pkg::PH_COV: begin
					div_ld  = 1'b1;
					div_num = prod;
					div_den = d_q;
				end
				rstr_pkg::PH_DRV: begin
					div_ld  = (j == 2'd2) && (theta_q[2] != '0);
					div_num = 128'(g_sh);
					div_den = 64'(theta_q[2]);
				end
				default: ;
			endcase
		end else if (state_q == rstr_pkg::ST_DPOST && phase_q == rstr_pkg::PH_COV && !pass_q) begin
			div_ld  = 1'b1;
			div_num = 128'(x_w) <<< rstr_pkg::LAMBDA_FRAC_BITS;
			div_den = signed'(64'(lam_eff));
		end
	end

	always_comb begin
		case (phase_q)
			rstr_pkg::PH_PPHI, rstr_pkg::PH_WROW, rstr_pkg::PH_COV: last_idx = 4'd15;
			rstr_pkg::PH_DRV: last_idx = 4'd2;
			default:          last_idx = 4'd3;
		endcase
		adv = ((state_q == rstr_pkg::ST_POST) && !div_ld
				&& !((phase_q == rstr_pkg::PH_DRV) && (j == 2'd2)))
			|| ((state_q == rstr_pkg::ST_DPOST) && !div_ld && (phase_q != rstr_pkg::PH_DRV));
	end

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			rstr_pkg::ST_IDLE:  if (s_tvalid) state_d = rstr_pkg::ST_FETCH;
			rstr_pkg::ST_FETCH: state_d = rstr_pkg::ST_MUL;
			rstr_pkg::ST_MUL:   if (mul_cnt_q == MUL_LAST) state_d = rstr_pkg::ST_POST;
			rstr_pkg::ST_POST: begin
				if (div_ld) state_d = rstr_pkg::ST_DIV;
				else if (phase_q == rstr_pkg::PH_DRV && j == 2'd2) state_d = rstr_pkg::ST_OUT;
				else state_d = rstr_pkg::ST_FETCH;
			end
			rstr_pkg::ST_DIV:   if (div_cnt_q == DIV_LAST) state_d = rstr_pkg::ST_DPOST;
			rstr_pkg::ST_DPOST: begin
				if (div_ld) state_d = rstr_pkg::ST_DIV;
				else if (phase_q == rstr_pkg::PH_DRV) state_d = rstr_pkg::ST_OUT;
				else state_d = rstr_pkg::ST_FETCH;
			end
			rstr_pkg::ST_OUT:   if (m_tready) state_d = rstr_pkg::ST_IDLE;
			default:            state_d = rstr_pkg::ST_IDLE;
		endcase
	end

	// outputs
	always_comb begin
		s_tready = (state_q == rstr_pkg::ST_IDLE);
		m_tvalid = (state_q == rstr_pkg::ST_OUT);
		cov_we   = (state_q == rstr_pkg::ST_DPOST) && (phase_q == rstr_pkg::PH_COV) && pass_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= rstr_pkg::ST_IDLE;
			phase_q   <= rstr_pkg::PH_TH;
			idx_q     <= '0;
			mul_cnt_q <= '0;
			div_cnt_q <= '0;
			pass_q    <= 1'b0;
			lam_q     <= rstr_pkg::LAMBDA_RST;
			lim_q     <= rstr_pkg::LIMIT_RST;
			icov_q    <= INIT_COV_RST;
			cov_vld_q <= '0;
			for (int k = 0; k < 4; k++) theta_q[k] <= THETA_ONE;
		end else begin
			state_q   <= state_d;
			mul_cnt_q <= (state_q == rstr_pkg::ST_MUL) ? 3'(mul_cnt_q + 3'd1) : '0;
			div_cnt_q <= (state_q == rstr_pkg::ST_DIV) ? 7'(div_cnt_q + 7'd1) : '0;
			if (accept) begin
				phase_q <= rstr_pkg::PH_TH;
				idx_q   <= '0;
				pass_q  <= 1'b0;
			end
			if (adv) begin
				if (idx_q == last_idx) begin
					idx_q <= '0;
					case (phase_q)
						rstr_pkg::PH_TH:   phase_q <= rstr_pkg::PH_PPHI;
						rstr_pkg::PH_PPHI: phase_q <= rstr_pkg::PH_WROW;
						rstr_pkg::PH_WROW: phase_q <= rstr_pkg::PH_QUAD;
						rstr_pkg::PH_QUAD: phase_q <= rstr_pkg::PH_THU;
						rstr_pkg::PH_THU:  phase_q <= rstr_pkg::PH_COV;
						default:           phase_q <= rstr_pkg::PH_DRV;
					endcase
				end else begin
					idx_q <= 4'(idx_q + 4'd1);
				end
			end
			if (state_q == rstr_pkg::ST_DPOST && phase_q == rstr_pkg::PH_COV) pass_q <= !pass_q;
			if (state_q == rstr_pkg::ST_DPOST && phase_q == rstr_pkg::PH_THU) theta_q[j] <= theta_new;
			if (cov_we) cov_vld_q[{i, j}] <= 1'b1;
			if (cfg_we) begin
				case (cfg_index)
					rstr_pkg::CFG_LAMBDA: lam_q <= cfg_data[rstr_pkg::LAMBDA_W-1:0];
					rstr_pkg::CFG_LIMIT:  lim_q <= cfg_data[rstr_pkg::LIMIT_W-1:0];
					rstr_pkg::CFG_INIT_COV: begin
						icov_q    <= cfg_data[rstr_pkg::ICOV_W-1:0];
						cov_vld_q <= '0;
					end
					default: ;
				endcase
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			sp_q  <= s_tdata[31:0];
			y_q   <= s_tdata[63:32];
			y1_q  <= s_tdata[95:64];
			y2_q  <= s_tdata[127:96];
			u1_q  <= s_tdata[159:128];
			u2_q  <= s_tdata[191:160];
			sum_q <= '0;
		end
		if (state_q == rstr_pkg::ST_MUL) begin
			if (mul_cnt_q == 3'd0) begin
				ma_q      <= rstr_pkg::mag64(op_a);
				mb_q      <= rstr_pkg::mag64(op_b);
				mneg_q    <= op_a[63] ^ op_b[63];
				macc_q    <= '0;
				cov_cur_q <= cov_rd;
			end
			if (mul_cnt_q >= 3'd1 && mul_cnt_q <= 3'd4) pp_q <= a_part * b_part;
			if (mul_cnt_q >= 3'd2) macc_q <= macc_q + pp_sh;
		end
		if (state_q == rstr_pkg::ST_POST) begin
			case (phase_q)
				rstr_pkg::PH_TH, rstr_pkg::PH_PPHI, rstr_pkg::PH_WROW,
				rstr_pkg::PH_QUAD, rstr_pkg::PH_DRV: begin
					sum_q <= end_grp ? '0 : sum_nx;
				end
				default: ;
			endcase
			if (end_grp) begin
				case (phase_q)
					rstr_pkg::PH_TH:   err_q <= rstr_pkg::sat32(128'(y_q) - sum_sh);
					rstr_pkg::PH_PPHI: pphi_q[i] <= quad_w;
					rstr_pkg::PH_WROW: wrow_q[i] <= quad_w;
					rstr_pkg::PH_QUAD: d_q <= (d_w == '0) ? 64'sd1 : d_w;
					rstr_pkg::PH_DRV: begin
						flag_q  <= (theta_q[2] == '0);
						drive_q <= 32'((g_w >= 0) ? lim64 : -lim64);
					end
					default: ;
				endcase
			end
		end
		if (div_ld) begin
			dn_q   <= div_num[127] ? 128'(-div_num) : 128'(div_num);
			dm_q   <= rstr_pkg::mag64(div_den);
			dneg_q <= div_num[127] ^ div_den[63];
			rem_q  <= '0;
		end else if (state_q == rstr_pkg::ST_DIV) begin
			dn_q  <= {dn_q[126:0], ge};
			rem_q <= ge ? 64'(rem_sh - {1'b0, dm_q}) : rem_sh[63:0];
		end
		if (state_q == rstr_pkg::ST_DPOST && phase_q == rstr_pkg::PH_DRV) begin
			if (q_res > lim64) drive_q <= 32'(lim64);
			else if (q_res < -lim64) drive_q <= 32'(-lim64);
			else drive_q <= 32'(q_res);
		end
	end

	rstr_ram #(
		.WIDTH(rstr_pkg::COV_W),
		.DEPTH(COV_DEPTH)
	) u_cov_ram (
		.clk  (clk),
		.we   (cov_we),
		.waddr({i, j}),
		.wdata(q_res),
		.raddr(cov_addr),
		.rdata(ram_rdata)
	);

	always_comb begin
		for (int k = 0; k < 4; k++) th64[k] = 64'(theta_q[k]);
	end

	assign m_tdata = {4'd0,
		th64[3][rstr_pkg::EST_W-1:0], th64[2][rstr_pkg::EST_W-1:0],
		th64[1][rstr_pkg::EST_W-1:0], th64[0][rstr_pkg::EST_W-1:0], drive_q};
	assign m_tuser = flag_q;

endmodule

>>> src/rstr_ram.sv
// Generic single-write, single-read RAM with registered read data.
module rstr_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

>>> test/tb_rls_self_tuning_regulator.sv
// Self-checking testbench for the RLS self-tuning regulator: queued stimulus, bit-true predictor.
module tb_rls_self_tuning_regulator;

	localparam int IDLE_LIMIT = 40000;

	typedef struct packed {
		logic [31:0] drive;
		logic [20:0] a1;
		logic [20:0] a2;
		logic [20:0] b0;
		logic [20:0] b1;
		logic        gain_zero;
	} regulator_out_t;

	logic                           clk;
	logic                           arst_n;
	logic                           s_tvalid;
	logic                           s_tready;
	logic [rstr_pkg::IN_W-1:0]      s_tdata;
	logic                           m_tvalid;
	logic                           m_tready;
	logic [rstr_pkg::OUT_W-1:0]     m_tdata;
	logic [0:0]                     m_tuser;
	logic                           cfg_we;
	logic [rstr_pkg::CFG_IDX_W-1:0] cfg_index;
	logic [rstr_pkg::CFG_W-1:0]     cfg_data;

	rls_self_tuning_regulator u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	// predictor state
	logic signed [63:0] theta [4];
	logic signed [63:0] cov_m [16];
	logic [16:0]        lambda_reg;
	logic [30:0]        limit_reg;
	logic [62:0]        icov_reg;

	logic [rstr_pkg::IN_W-1:0] sample_q [$];
	regulator_out_t     expected_q [$];
	int                 fail_cnt;
	int                 send_gap;
	int                 recv_gap;
	int                 quiet_cnt;

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	function automatic logic signed [127:0] wide(input logic signed [63:0] v);
		return {{64{v[63]}}, v};
	endfunction

	function automatic logic signed [63:0] clip64(input logic signed [127:0] v);
		if ((&v[127:63]) || !(|v[127:63])) return v[63:0];
		return v[127] ? 64'sh8000_0000_0000_0000 : 64'sh7FFF_FFFF_FFFF_FFFF;
	endfunction

	function automatic logic signed [63:0] clip32(input logic signed [63:0] v);
		if (v > 64'sd2147483647) return 64'sd2147483647;
		if (v < -64'sd2147483648) return -64'sd2147483648;
		return v;
	endfunction

	// signed 128 / 64, truncating toward zero, saturated to 64 bits
	function automatic logic signed [63:0] quot(input logic signed [127:0] n,
			input logic signed [63:0] d);
		logic [127:0] nm;
		logic [127:0] dm;
		logic [127:0] q;
		logic         neg;
		neg = n[127] ^ d[63];
		nm = n[127] ? 128'(-n) : 128'(n);
		dm = {64'd0, d[63] ? 64'(-d) : 64'(d)};
		q = nm / dm;
		if (q > {64'd0, 64'h8000_0000_0000_0000})
			return neg ? 64'sh8000_0000_0000_0000 : 64'sh7FFF_FFFF_FFFF_FFFF;
		if (neg) return -q[63:0];
		if (q[63]) return 64'sh7FFF_FFFF_FFFF_FFFF;
		return q[63:0];
	endfunction

	function automatic void load_cov();
		for (int i = 0; i < 16; i++)
			cov_m[i] = (i % 5 == 0) ? $signed({1'b0, icov_reg}) : 64'sd0;
	endfunction

	function automatic void apply_reg(input logic [rstr_pkg::CFG_IDX_W-1:0] idx,
			input logic [62:0] val);
		if (idx == rstr_pkg::CFG_LAMBDA) lambda_reg = val[16:0];
		else if (idx == rstr_pkg::CFG_LIMIT) limit_reg = val[30:0];
		else if (idx == rstr_pkg::CFG_INIT_COV) begin
			icov_reg = val;
			load_cov();
		end
	endfunction

	function automatic regulator_out_t regulate(input logic [rstr_pkg::IN_W-1:0] smp);
		logic signed [63:0]  sp, y, y1, y2, u1, u2;
		logic signed [63:0]  phi [4];
		logic signed [63:0]  pphi [4];
		logic signed [63:0]  wrow [4];
		logic signed [63:0]  acc, err, quad, lam, d, delta, t, qv, x, g, drv, lim, pmax;
		logic signed [127:0] s, r;
		regulator_out_t      o;
		sp = $signed(smp[31:0]);
		y  = $signed(smp[63:32]);
		y1 = $signed(smp[95:64]);
		y2 = $signed(smp[127:96]);
		u1 = $signed(smp[159:128]);
		u2 = $signed(smp[191:160]);
		lim = $signed({33'd0, limit_reg});
		pmax = 64'sd655360;
		phi[0] = clip32(-y1);
		phi[1] = clip32(-y2);
		phi[2] = u1;
		phi[3] = u2;
		acc = 0;
		for (int i = 0; i < 4; i++) acc = acc + theta[i] * phi[i];
		err = clip32(y - (acc >>> 16));
		for (int i = 0; i < 4; i++) begin
			s = 0;
			r = 0;
			for (int j = 0; j < 4; j++) begin
				s = s + wide(cov_m[i*4+j]) * wide(phi[j]);
				r = r + wide(phi[j]) * wide(cov_m[j*4+i]);
			end
			pphi[i] = clip64(s >>> 16);
			wrow[i] = clip64(r >>> 16);
		end
		s = 0;
		for (int i = 0; i < 4; i++) s = s + wide(phi[i]) * wide(pphi[i]);
		quad = clip64(s >>> 16);
		lam = (lambda_reg == 0) ? 64'sd1 : $signed({47'd0, lambda_reg});
		d = clip64(wide(lam <<< 16) + wide(quad));
		if (d == 0) d = 1;
		for (int i = 0; i < 4; i++) begin
			delta = quot(wide(pphi[i]) * wide(err), d);
			if (delta > 64'sh1_0000_0000) delta = 64'sh1_0000_0000;
			if (delta < -64'sh1_0000_0000) delta = -64'sh1_0000_0000;
			t = theta[i] + delta;
			if (t > pmax) t = pmax;
			if (t < -pmax) t = -pmax;
			theta[i] = t;
		end
		for (int i = 0; i < 4; i++)
			for (int j = 0; j < 4; j++) begin
				qv = quot(wide(pphi[i]) * wide(wrow[j]), d);
				x = clip64(wide(cov_m[i*4+j]) - wide(qv));
				cov_m[i*4+j] = quot(wide(x) <<< 16, lam);
			end
		g = sp + ((theta[0] * y + theta[1] * y1 - theta[3] * u1) >>> 16);
		o.gain_zero = (theta[2] == 0);
		if (theta[2] == 0) drv = (g >= 0) ? lim : -lim;
		else begin
			drv = (g * 64'sd65536) / theta[2];
			if (drv > lim) drv = lim;
			if (drv < -lim) drv = -lim;
		end
		o.drive = drv[31:0];
		o.a1 = theta[0][20:0];
		o.a2 = theta[1][20:0];
		o.b0 = theta[2][20:0];
		o.b1 = theta[3][20:0];
		return o;
	endfunction

	// driver
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_tvalid <= 1'b0;
			s_tdata  <= '0;
			send_gap <= 0;
		end else begin
			if (s_tvalid && s_tready) expected_q.push_back(regulate(s_tdata));
			if (!(s_tvalid && !s_tready)) begin
				if (send_gap > 0) begin
					send_gap <= send_gap - 1;
					s_tvalid <= 1'b0;
				end else if (sample_q.size() > 0) begin
					s_tdata  <= sample_q.pop_front();
					s_tvalid <= 1'b1;
					send_gap <= $urandom_range(0, 4);
				end else begin
					s_tvalid <= 1'b0;
				end
			end
		end
	end

	// monitor
	always @(posedge clk or negedge arst_n) begin
		regulator_out_t got;
		regulator_out_t want;
		if (!arst_n) begin
			m_tready <= 1'b0;
			recv_gap <= 0;
		end else begin
			if (m_tvalid && m_tready) begin
				got = {m_tdata[31:0], m_tdata[52:32], m_tdata[73:53], m_tdata[94:74],
					m_tdata[115:95], m_tuser[0]};
				if (expected_q.size() == 0) begin
					$display("%0t: unexpected item, expected none, actual %h", $time, got);
					fail_cnt++;
				end else begin
					want = expected_q.pop_front();
					if (got.drive !== want.drive) begin
						$display("%0t: drive expected %h actual %h", $time, want.drive, got.drive);
						fail_cnt++;
					end
					if (got.a1 !== want.a1) begin
						$display("%0t: est_a1 expected %h actual %h", $time, want.a1, got.a1);
						fail_cnt++;
					end
					if (got.a2 !== want.a2) begin
						$display("%0t: est_a2 expected %h actual %h", $time, want.a2, got.a2);
						fail_cnt++;
					end
					if (got.b0 !== want.b0) begin
						$display("%0t: est_b0 expected %h actual %h", $time, want.b0, got.b0);
						fail_cnt++;
					end
					if (got.b1 !== want.b1) begin
						$display("%0t: est_b1 expected %h actual %h", $time, want.b1, got.b1);
						fail_cnt++;
					end
					if (got.gain_zero !== want.gain_zero) begin
						$display("%0t: gain_zero expected %b actual %b", $time,
							want.gain_zero, got.gain_zero);
						fail_cnt++;
					end
				end
			end
			if (recv_gap > 0) begin
				recv_gap <= recv_gap - 1;
				m_tready <= 1'b0;
			end else begin
				m_tready <= 1'b1;
				if (m_tvalid && m_tready) recv_gap <= $urandom_range(0, 4);
			end
		end
	end

	// watchdog
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) quiet_cnt <= 0;
		else if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) quiet_cnt <= 0;
		else if (quiet_cnt >= IDLE_LIMIT) begin
			$display("status: fail");
			$finish;
		end else quiet_cnt <= quiet_cnt + 1;
	end

	function automatic logic [31:0] rand_signal(input bit moderate);
		logic [31:0] v;
		if (moderate) v = $urandom_range(0, 20 << 16) - (10 << 16);
		else v = $urandom;
		return v;
	endfunction

	function automatic logic [rstr_pkg::IN_W-1:0] rand_sample();
		logic [rstr_pkg::IN_W-1:0] smp;
		bit              moderate;
		moderate = ($urandom_range(0, 9) < 8);
		for (int f = 0; f < 6; f++) smp[f*32 +: 32] = rand_signal(moderate);
		return smp;
	endfunction

	function automatic logic [rstr_pkg::IN_W-1:0] pack_sample(input logic [31:0] sp, y, y1,
			y2, u1, u2);
		return {u2, u1, y2, y1, y, sp};
	endfunction

	task automatic write_reg(input logic [rstr_pkg::CFG_IDX_W-1:0] idx, input logic [62:0] val);
		@(posedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		apply_reg(idx, val);
		@(posedge clk);
		cfg_we    <= 1'b0;
	endtask

	task automatic drain();
		while (sample_q.size() > 0 || s_tvalid || expected_q.size() > 0) @(posedge clk);
		repeat (20) @(posedge clk);
	endtask

	task automatic run_phase(input logic [16:0] lam, input logic [30:0] lim,
			input logic [62:0] icov, input int count);
		write_reg(rstr_pkg::CFG_LAMBDA, lam);
		write_reg(rstr_pkg::CFG_LIMIT, lim);
		write_reg(rstr_pkg::CFG_INIT_COV, icov);
		for (int k = 0; k < count; k++) sample_q.push_back(rand_sample());
		drain();
	endtask

	initial begin
		fail_cnt   = 0;
		arst_n     = 1'b0;
		cfg_we     = 1'b0;
		cfg_index  = rstr_pkg::CFG_LAMBDA;
		cfg_data   = '0;
		theta      = '{4{64'sd65536}};
		lambda_reg = 17'd65536;
		limit_reg  = 31'h7FFF_FFFF;
		icov_reg   = 63'd1000000 << 32;
		load_cov();
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: default registers, field extremes, saturating negation
		sample_q.push_back(pack_sample(0, 0, 0, 0, 0, 0));
		sample_q.push_back(pack_sample(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
			32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF));
		sample_q.push_back(pack_sample(32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
			32'h8000_0000, 32'h8000_0000, 32'h8000_0000));
		sample_q.push_back(pack_sample(32'hFFFF_FFFF, 32'h0001_0000, 32'h8000_0000,
			32'h7FFF_FFFF, 32'hFFFF_0000, 32'h0000_0001));
		sample_q.push_back(pack_sample(32'h0001_0000, 32'h0002_0000, 32'h0001_8000,
			32'h0001_0000, 32'h0000_8000, 32'hFFFF_8000));
		sample_q.push_back(pack_sample(32'hFFF6_0000, 32'h000A_0000, 32'hFFF6_0000,
			32'h000A_0000, 32'hFFF6_0000, 32'h000A_0000));
		drain();
		// zero covariance and zero forgetting factor, zero drive limit
		write_reg(rstr_pkg::CFG_LAMBDA, 17'd0);
		write_reg(rstr_pkg::CFG_LIMIT, 31'd0);
		write_reg(rstr_pkg::CFG_INIT_COV, 63'd0);
		sample_q.push_back(pack_sample(32'h0001_0000, 32'h0003_0000, 32'h0001_0000,
			32'h0002_0000, 32'h0001_0000, 32'h0000_8000));
		sample_q.push_back(pack_sample(0, 0, 0, 0, 0, 0));
		sample_q.push_back(pack_sample(32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000,
			32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF));
		drain();
		// lambda at its top, huge covariance: saturating paths
		write_reg(rstr_pkg::CFG_LAMBDA, 17'h1FFFF);
		write_reg(rstr_pkg::CFG_LIMIT, 31'h7FFF_FFFF);
		write_reg(rstr_pkg::CFG_INIT_COV, 63'h7FFF_FFFF_FFFF_FFFF);
		sample_q.push_back(pack_sample(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF,
			32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000));
		sample_q.push_back(pack_sample(32'h0001_0000, 32'h0001_0000, 32'h0001_0000,
			32'h0001_0000, 32'h0001_0000, 32'h0001_0000));
		sample_q.push_back(pack_sample(0, 0, 0, 0, 0, 0));
		sample_q.push_back(pack_sample(32'hFFFF_0000, 32'h0010_0000, 32'hFFF0_0000,
			32'h0008_0000, 32'hFFFF_FFFF, 32'h0000_0001));
		drain();

		run_phase(17'd64225, 31'd100 << 16, 63'd1000 << 32, 80);
		run_phase(17'd1, 31'd0, 63'd1, 60);
		run_phase(17'd65536, 31'h7FFF_FFFF, 63'd1000000 << 32, 80);
		run_phase(17'h1FFFF, 31'd5 << 16, 63'h7FFF_FFFF_FFFF_FFFF, 60);
		run_phase(17'd0, 31'd1, 63'd10 << 32, 40);
		run_phase(17'd62259, 31'd1000 << 16, 63'd100 << 32, 80);

		if (fail_cnt == 0) $display("status: pass");
		else $display("status: fail");
		$finish;
	end

endmodule

>>> filelist.f
src/rstr_pkg.sv
src/rstr_ram.sv
src/rls_self_tuning_regulator.sv
test/tb_rls_self_tuning_regulator.sv
